// File: rtl/core/multichannel_pcm_stereo_mixer_unit_assert.svh
// Assertion macros for the PCM stereo mixer core.
// Taken in by `include in the modules that check their own logic.
`ifndef MULTICHANNEL_PCM_STEREO_MIXER_UNIT_ASSERT_SVH
`define MULTICHANNEL_PCM_STEREO_MIXER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MPSM_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define MPSM_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/mpsm_pkg.sv
// Shared types, constants and the level function of the PCM stereo mixer.
// No dependencies.
`timescale 1ns / 1ps

package mpsm_pkg;

	localparam int CHANNELS   = 16;
	localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int LEN_W      = 24;
	localparam int ACC_W      = 20;
	localparam int MASK_W     = 16;
	localparam int OPQ_DEPTH  = 4;
	localparam int OPQ_PTR_W  = 2;
	localparam int OUTQ_DEPTH = 2;
	localparam int OUTQ_PTR_W = 1;

	localparam logic signed [ACC_W:0] SUM_MAX = (ACC_W+1)'((1 << (ACC_W - 1)) - 1);
	localparam logic signed [ACC_W:0] SUM_MIN = -(ACC_W+1)'(1 << (ACC_W - 1));

	// Reciprocal of 15 in Q16, rounded up; exact floor for products up to 3825.
	localparam logic [12:0] LVL_RECIP = 13'd4370;
	localparam logic [7:0]  SEP_FULL  = 8'd255;
	localparam logic [8:0]  PCM_MID   = 9'd128;

	typedef enum logic [1:0] {
		FUNC_START  = 2'd0,
		FUNC_UPDATE = 2'd1,
		FUNC_STOP   = 2'd2,
		FUNC_MIX    = 2'd3
	} func_t;

	// Decoded transaction handed from the front end to the back end.
	typedef struct packed {
		func_t                func;
		logic                 in_range;
		logic [CH_IDX_W-1:0]  idx;
		logic [7:0]           left_lvl;
		logic [7:0]           right_lvl;
		logic [LEN_W-1:0]     length;
		logic signed [8:0]    centred;
		logic                 last;
	} op_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] left_mix;
		logic signed [ACC_W-1:0] right_mix;
		logic [MASK_W-1:0]       active;
	} res_t;

	// (sep * vol) / 15 clamped to 8 bits, given the product.
	function automatic logic [7:0] level_of(input logic [11:0] prod);
		logic [24:0] q;
		q = 25'(prod) * 25'(LVL_RECIP);
		return (q[24:16] > 9'd255) ? 8'd255 : q[23:16];
	endfunction

endpackage

// File: rtl/core/mpsm_front.sv
// Front end: takes transactions, decodes them and works out channel levels.
// Depends on mpsm_pkg.
`timescale 1ns / 1ps

module mpsm_front import mpsm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          func,
	input  logic [3:0]          channel,
	input  logic [3:0]          volume,
	input  logic [7:0]          separation,
	input  logic [LEN_W-1:0]    length,
	input  logic [7:0]          sample,
	input  logic                last_in_frame,
	input  logic                q_full,
	output logic                q_push,
	output op_t                 q_op
);

	typedef struct packed {
		func_t               func;
		logic                in_range;
		logic [CH_IDX_W-1:0] idx;
		logic [11:0]         prod_l;
		logic [11:0]         prod_r;
		logic [LEN_W-1:0]    length;
		logic signed [8:0]   centred;
		logic                last;
	} dec_t;

	logic  valid_s1, valid_s2;
	dec_t  dec_s1;
	op_t   op_s2;
	logic  adv;
	logic  take;

	// The two stages move together; they hold only when the queue is full.
	assign adv  = !(valid_s2 && q_full);
	assign full = !adv;
	assign take = push && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s1.func     <= func_t'(func);
			dec_s1.in_range <= (int'(channel) < CHANNELS);
			dec_s1.idx      <= CH_IDX_W'(channel);
			dec_s1.prod_l   <= 12'(SEP_FULL - separation) * 12'(volume);
			dec_s1.prod_r   <= 12'(separation) * 12'(volume);
			dec_s1.length   <= length;
			dec_s1.centred  <= $signed({1'b0, sample}) - $signed(PCM_MID);
			dec_s1.last     <= last_in_frame;

			op_s2.func      <= dec_s1.func;
			op_s2.in_range  <= dec_s1.in_range;
			op_s2.idx       <= dec_s1.idx;
			op_s2.left_lvl  <= level_of(dec_s1.prod_l);
			op_s2.right_lvl <= level_of(dec_s1.prod_r);
			op_s2.length    <= dec_s1.length;
			op_s2.centred   <= dec_s1.centred;
			op_s2.last      <= dec_s1.last;
		end
	end

	assign q_push = valid_s2 && !q_full;
	assign q_op   = op_s2;

endmodule

// File: rtl/core/mpsm_opq.sv
// Short queue of decoded transactions between front and back ends.
// Depends on mpsm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "multichannel_pcm_stereo_mixer_unit_assert.svh"

module mpsm_opq import mpsm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output op_t  head,
	output logic valid
);

	op_t                  mem [OPQ_DEPTH];
	logic [OPQ_PTR_W-1:0] wr_q, rd_q;
	logic [OPQ_PTR_W:0]   cnt_q;
	logic                 do_push, do_pop;

	assign full    = (cnt_q == (OPQ_PTR_W+1)'(OPQ_DEPTH));
	assign valid   = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign head    = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_q] <= push_op;
	end

	`MPSM_ASSERT_NOW(a_opq_cnt_bound, clk, arst_n, 1'b1,
		cnt_q <= (OPQ_PTR_W+1)'(OPQ_DEPTH), "op queue count overrun")
	`MPSM_ASSERT_NOW(a_opq_no_push_full, clk, arst_n, full, !push,
		"front end pushed into a full op queue")
	`MPSM_ASSERT_NEXT(a_opq_pop_drains, clk, arst_n, do_pop && !do_push && cnt_q == 1,
		!valid, "op queue not empty after last entry popped")

endmodule

// File: rtl/core/mpsm_back.sv
// Back end: channel state, stereo accumulators, frame countdown, result queue.
// Depends on mpsm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "multichannel_pcm_stereo_mixer_unit_assert.svh"

module mpsm_back import mpsm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  op_t  op,
	input  logic op_valid,
	output logic op_pop,
	output logic empty,
	input  logic pop,
	output res_t res
);

	logic [CHANNELS-1:0] act_q, act_d;
	logic [7:0]          lvl_l_q [CHANNELS];
	logic [7:0]          lvl_r_q [CHANNELS];
	logic [7:0]          lvl_l_d [CHANNELS];
	logic [7:0]          lvl_r_d [CHANNELS];
	logic [LEN_W-1:0]    left_q  [CHANNELS];
	logic [LEN_W-1:0]    left_d  [CHANNELS];
	logic [CHANNELS-1:0] len_zero;

	logic signed [ACC_W-1:0] acc_l_q, acc_r_q, sat_l, sat_r;
	logic signed [ACC_W:0]   sum_l, sum_r;
	logic signed [14:0]      prod_l, prod_r;
	logic [7:0]              sel_l, sel_r;
	logic                    mix_on;
	logic [MASK_W-1:0]       mask;

	res_t                  outq [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] owr_q, ord_q;
	logic [OUTQ_PTR_W:0]   ocnt_q;
	logic                  out_full, fire, emit, take;

	assign out_full = (ocnt_q == (OUTQ_PTR_W+1)'(OUTQ_DEPTH));
	assign fire     = op_valid && (!op.last || !out_full);
	assign op_pop   = fire;
	assign emit     = fire && op.last;
	assign empty    = (ocnt_q == '0);
	assign take     = pop && !empty;
	assign res      = outq[ord_q];

	// Mix path: one 9x6 signed product per side, then a saturating add.
	assign sel_l  = lvl_l_q[op.idx];
	assign sel_r  = lvl_r_q[op.idx];
	assign mix_on = op.in_range && (op.func == FUNC_MIX) && act_q[op.idx];
	assign prod_l = op.centred * $signed({1'b0, sel_l[7:3]});
	assign prod_r = op.centred * $signed({1'b0, sel_r[7:3]});

	always_comb begin
		sum_l = (ACC_W+1)'(acc_l_q);
		sum_r = (ACC_W+1)'(acc_r_q);
		if (mix_on) begin
			sum_l = sum_l + ((ACC_W+1)'(prod_l) <<< 3);
			sum_r = sum_r + ((ACC_W+1)'(prod_r) <<< 3);
		end
		if (sum_l > SUM_MAX)
			sat_l = ACC_W'(SUM_MAX);
		else if (sum_l < SUM_MIN)
			sat_l = ACC_W'(SUM_MIN);
		else
			sat_l = ACC_W'(sum_l);
		if (sum_r > SUM_MAX)
			sat_r = ACC_W'(SUM_MAX);
		else if (sum_r < SUM_MIN)
			sat_r = ACC_W'(SUM_MIN);
		else
			sat_r = ACC_W'(sum_r);
	end

	// Channel command, then the frame countdown when the frame closes.
	always_comb begin
		act_d   = act_q;
		lvl_l_d = lvl_l_q;
		lvl_r_d = lvl_r_q;
		left_d  = left_q;
		if (op.in_range) begin
			case (op.func)
				FUNC_START: begin
					lvl_l_d[op.idx] = op.left_lvl;
					lvl_r_d[op.idx] = op.right_lvl;
					left_d[op.idx]  = op.length;
					act_d[op.idx]   = (op.length != '0);
				end
				FUNC_UPDATE: begin
					if (act_q[op.idx]) begin
						lvl_l_d[op.idx] = op.left_lvl;
						lvl_r_d[op.idx] = op.right_lvl;
					end
				end
				FUNC_STOP: act_d[op.idx] = 1'b0;
				default: ;
			endcase
		end
		if (op.last) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (act_d[i]) begin
					if (left_d[i] != '0)
						left_d[i] = left_d[i] - LEN_W'(1);
					if (left_d[i] == '0)
						act_d[i] = 1'b0;
				end
			end
		end
	end

	for (genvar g = 0; g < MASK_W; g++) begin : g_mask
		if (g < CHANNELS) begin : g_on
			assign mask[g] = act_d[g];
		end else begin : g_off
			assign mask[g] = 1'b0;
		end
	end

	for (genvar g = 0; g < CHANNELS; g++) begin : g_zero
		assign len_zero[g] = (left_q[g] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= '0;
			acc_l_q <= '0;
			acc_r_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				lvl_l_q[i] <= '0;
				lvl_r_q[i] <= '0;
				left_q[i]  <= '0;
			end
		end else if (fire) begin
			act_q   <= act_d;
			lvl_l_q <= lvl_l_d;
			lvl_r_q <= lvl_r_d;
			left_q  <= left_d;
			acc_l_q <= op.last ? '0 : sat_l;
			acc_r_q <= op.last ? '0 : sat_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (emit)
				owr_q <= owr_q + 1'b1;
			if (take)
				ord_q <= ord_q + 1'b1;
			case ({emit, take})
				2'b10:   ocnt_q <= ocnt_q + 1'b1;
				2'b01:   ocnt_q <= ocnt_q - 1'b1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			outq[owr_q] <= '{left_mix: sat_l, right_mix: sat_r, active: mask};
	end

	`MPSM_ASSERT_NOW(a_back_outq_bound, clk, arst_n, 1'b1,
		ocnt_q <= (OUTQ_PTR_W+1)'(OUTQ_DEPTH), "result queue overrun")
	`MPSM_ASSERT_NEXT(a_back_acc_clear, clk, arst_n, emit,
		acc_l_q == '0 && acc_r_q == '0, "accumulators not cleared at frame end")
	`MPSM_ASSERT_NOW(a_back_active_len, clk, arst_n, 1'b1,
		(act_q & len_zero) == '0, "active channel with no length left")
	`MPSM_ASSERT_NEXT(a_back_emit_shows, clk, arst_n, emit, !empty,
		"frame result not queued")

endmodule

// File: rtl/core/multichannel_pcm_stereo_mixer_unit.sv
// Top level of the multichannel 8-bit PCM stereo mixer.
// Depends on mpsm_pkg, mpsm_front, mpsm_opq and mpsm_back.
`timescale 1ns / 1ps
//
//  channel   handshake       payload
//  -------   -------------   --------------------------------------------------
//  input     push / full     func, channel, volume, separation, length,
//                            sample, last_in_frame
//  result    empty / pop     left_mix, right_mix, active_channels
//
//  One transaction per cycle sustained while full is low. In the front end a
//  transaction passes stage s1 (volume x separation product), then stage s2
//  (the divide by 15 as a reciprocal multiply), passes the op queue and is
//  executed by the back end; a frame result is queued when the back end
//  executes the frame's last item. Reset (arst_n low) clears channel state,
//  accumulators and all queues at once; no clearing pass follows.
//  The back end holds only while the two-entry result queue is full and the
//  op at its head closes a frame; the front end holds (full high) only while
//  its four-entry op queue is full.

module multichannel_pcm_stereo_mixer_unit import mpsm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [1:0]               func,
	input  logic [3:0]               channel,
	input  logic [3:0]               volume,
	input  logic [7:0]               separation,
	input  logic [LEN_W-1:0]         length,
	input  logic [7:0]               sample,
	input  logic                     last_in_frame,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [ACC_W-1:0]  left_mix,
	output logic signed [ACC_W-1:0]  right_mix,
	output logic [MASK_W-1:0]        active_channels
);

	// Front end to op queue.
	logic q_full, q_push;
	op_t  q_in;

	// Op queue to back end.
	op_t  q_head;
	logic q_valid, q_pop;

	res_t res;

	// Decode and level computation. Stateless apart from its pipeline, so
	// every channel-state hazard is settled in the back end alone.
	mpsm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.func          (func),
		.channel       (channel),
		.volume        (volume),
		.separation    (separation),
		.length        (length),
		.sample        (sample),
		.last_in_frame (last_in_frame),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_op          (q_in)
	);

	// Decouples the front end from back-end stalls on the result side.
	mpsm_opq u_opq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (q_in),
		.full    (q_full),
		.pop     (q_pop),
		.head    (q_head),
		.valid   (q_valid)
	);

	// Channel table, accumulators, countdown and the result queue.
	mpsm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (q_head),
		.op_valid (q_valid),
		.op_pop   (q_pop),
		.empty    (empty),
		.pop      (pop),
		.res      (res)
	);

	assign left_mix        = res.left_mix;
	assign right_mix       = res.right_mix;
	assign active_channels = res.active;

endmodule
